FILE: hw/rtl/alr_pkg.sv
// Shared types, constants and helpers for the audio loop recorder.
package alr_pkg;

	localparam int unsigned SAMPLE_BITS = 24;
	localparam int unsigned LOOP_DEPTH  = 2097152;
	localparam int unsigned ADDR_W      = $clog2(LOOP_DEPTH);
	localparam int unsigned POS_W       = $clog2(LOOP_DEPTH + 1);
	localparam int unsigned FIELD_W     = 22;
	localparam int unsigned GAIN_FRAC   = 25;
	localparam int unsigned GAIN_W      = 26;
	localparam int unsigned PROD_W      = SAMPLE_BITS + GAIN_W;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SAMPLE_BITS+1:0] wide_t;
	typedef logic [ADDR_W-1:0]             addr_t;
	typedef logic [POS_W-1:0]              pos_t;
	typedef logic [FIELD_W-1:0]            field_t;
	typedef logic signed [PROD_W-1:0]      prod_t;

	// 0.8 in Q.25
	localparam logic signed [GAIN_W-1:0] PLAY_GAIN = GAIN_W'(26843546);
	localparam prod_t PROD_ROUND = prod_t'(longint'(1) << (GAIN_FRAC - 1));
	localparam pos_t  DEPTH_POS  = pos_t'(LOOP_DEPTH);

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_REC  = 2'd1,
		MODE_PLAY = 2'd2,
		MODE_DUB  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CMD_OFF   = 3'd0,
		CMD_REC   = 3'd1,
		CMD_PLAY  = 3'd2,
		CMD_DUB   = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_t;

	// decoded item, leaves the control stage at accept
	typedef struct packed {
		logic    mix;
		logic    dub;
		logic    wr;
		addr_t   addr;
		sample_t x;
		mode_t   mode;
		pos_t    pos;
		pos_t    len;
	} req_t;

	// item after the gain multiply
	typedef struct packed {
		prod_t   prod;
		sample_t x;
		logic    mix;
		mode_t   mode;
		pos_t    pos;
		pos_t    len;
	} mix_req_t;

	function automatic sample_t sat_sample(input wide_t v);
		sample_t r;
		if (v > wide_t'(SAMPLE_MAX)) begin
			r = SAMPLE_MAX;
		end else if (v < wide_t'(SAMPLE_MIN)) begin
			r = SAMPLE_MIN;
		end else begin
			r = sample_t'(v);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/alr_ctrl.sv
// Looper mode, position and length state; decodes each accepted item.
module alr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             operation,
	input  alr_pkg::sample_t sample_in,
	input  logic [2:0]       command,
	output alr_pkg::req_t    req
);

	alr_pkg::mode_t mode_q, mode_n;
	alr_pkg::pos_t  pos_q, pos_n;
	alr_pkg::pos_t  len_q, len_n;
	alr_pkg::pos_t  idx_pos;
	alr_pkg::pos_t  pos_inc;
	alr_pkg::cmd_t  cmd;
	logic           mix, dub, wr;

	assign cmd     = alr_pkg::cmd_t'(command);
	assign idx_pos = (pos_q < alr_pkg::DEPTH_POS) ? pos_q : '0;
	assign pos_inc = idx_pos + alr_pkg::pos_t'(1);

	always_comb begin
		mode_n = mode_q;
		pos_n  = pos_q;
		len_n  = len_q;
		mix    = 1'b0;
		dub    = 1'b0;
		wr     = 1'b0;
		if (operation) begin
			unique case (cmd) inside
				alr_pkg::CMD_CLEAR: begin
					mode_n = alr_pkg::MODE_OFF;
					pos_n  = '0;
					len_n  = '0;
				end
				alr_pkg::CMD_REC: begin
					mode_n = alr_pkg::MODE_REC;
					pos_n  = '0;
					len_n  = '0;
				end
				alr_pkg::CMD_OFF, alr_pkg::CMD_PLAY, alr_pkg::CMD_DUB: begin
					mode_n = alr_pkg::mode_t'(command[1:0]);
					pos_n  = '0;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (mode_q)
				alr_pkg::MODE_REC: begin
					wr    = 1'b1;
					pos_n = pos_inc;
					if (pos_inc > len_q) begin
						len_n = pos_inc;
					end
					// store full: wrap and play
					if (pos_inc == alr_pkg::DEPTH_POS) begin
						pos_n  = '0;
						mode_n = alr_pkg::MODE_PLAY;
					end
				end
				alr_pkg::MODE_PLAY, alr_pkg::MODE_DUB: begin
					if (len_q != '0) begin
						mix   = 1'b1;
						dub   = (mode_q == alr_pkg::MODE_DUB);
						pos_n = (pos_inc >= len_q) ? '0 : pos_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		req      = '0;
		req.mix  = mix;
		req.dub  = dub;
		req.wr   = wr;
		req.addr = alr_pkg::addr_t'(idx_pos);
		req.x    = operation ? '0 : sample_in;
		req.mode = mode_n;
		req.pos  = pos_n;
		req.len  = len_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= alr_pkg::MODE_OFF;
			pos_q  <= '0;
			len_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			len_q  <= len_n;
		end
	end

	a_play_pos_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		((mode_q == alr_pkg::MODE_PLAY) || (mode_q == alr_pkg::MODE_DUB)) && (len_q != '0)
		|-> (pos_q < len_q))
		else $error("play position outside loop");

	a_rec_pos_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == alr_pkg::MODE_REC) |-> (pos_q <= len_q) && (pos_q < alr_pkg::DEPTH_POS))
		else $error("record position out of bounds");

endmodule

FILE: hw/rtl/alr_store.sv
// Loop memory with read-modify-write for overdub, forwarding and the gain multiply.
module alr_store (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  alr_pkg::req_t      req,
	input  logic               out_ready,
	output logic               s1_ready,
	output logic               stage_valid,
	output alr_pkg::mix_req_t  stage
);

	typedef logic signed [alr_pkg::SAMPLE_BITS+2:0] dsum_t;

	alr_pkg::sample_t   mem [alr_pkg::LOOP_DEPTH];

	logic               valid_s1;
	alr_pkg::req_t      req_s1;
	alr_pkg::sample_t   rd_s1;
	logic               valid_s2;
	alr_pkg::mix_req_t  stage_s2;

	logic               fwd_v_q;
	alr_pkg::addr_t     fwd_addr_q;
	alr_pkg::sample_t   fwd_data_q;

	logic               s2_ready, s1_adv;
	logic               rd_en, dub_wr, rec_wr, wr_en;
	alr_pkg::addr_t     wr_addr;
	alr_pkg::sample_t   wr_data;
	alr_pkg::sample_t   loop_val;
	dsum_t              dub_sum;
	alr_pkg::sample_t   dub_val;

	assign s2_ready = !valid_s2 || out_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign s1_adv   = valid_s1 && s2_ready;

	// a write on the edge that issued this read is not in rd_s1 yet
	assign loop_val = (fwd_v_q && (fwd_addr_q == req_s1.addr)) ? fwd_data_q : rd_s1;

	// loop + 0.75 * in, rounded half up
	assign dub_sum = (dsum_t'(loop_val) <<< 2) + (dsum_t'(req_s1.x) <<< 1)
		+ dsum_t'(req_s1.x) + dsum_t'(2);
	assign dub_val = alr_pkg::sat_sample(alr_pkg::wide_t'(dub_sum >>> 2));

	assign rd_en   = accept && req.mix;
	assign dub_wr  = s1_adv && req_s1.dub;
	assign rec_wr  = accept && req.wr;
	assign wr_en   = dub_wr || rec_wr;
	assign wr_addr = dub_wr ? req_s1.addr : req.addr;
	assign wr_data = dub_wr ? dub_val : req.x;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fwd_v_q  <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= accept;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
			if (wr_en) begin
				fwd_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (wr_en) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
		if (s1_adv) begin
			stage_s2.prod <= alr_pkg::prod_t'(loop_val) * alr_pkg::prod_t'(alr_pkg::PLAY_GAIN);
			stage_s2.x    <= req_s1.x;
			stage_s2.mix  <= req_s1.mix;
			stage_s2.mode <= req_s1.mode;
			stage_s2.pos  <= req_s1.pos;
			stage_s2.len  <= req_s1.len;
		end
	end

	assign stage_valid = valid_s2;
	assign stage       = stage_s2;

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(dub_wr && rec_wr))
		else $error("overdub and record write on the same edge");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_ready |=> $stable(rd_s1) && $stable(req_s1))
		else $error("held read stage changed");

endmodule

FILE: hw/rtl/alr_mix.sv
// For mix items rounds the scaled loop sample, adds the input, saturates; output register.
module alr_mix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        stage_valid,
	input  alr_pkg::mix_req_t           stage,
	input  logic                        out_stall,
	output logic                        ready,
	output logic                        out_valid,
	output logic signed [alr_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [1:0]                  loop_mode,
	output alr_pkg::field_t             loop_position,
	output alr_pkg::field_t             loop_length
);

	logic              valid_q;
	alr_pkg::sample_t  sample_q;
	alr_pkg::mode_t    mode_q;
	alr_pkg::pos_t     pos_q;
	alr_pkg::pos_t     len_q;

	alr_pkg::prod_t    rnd;
	alr_pkg::wide_t    sum;
	alr_pkg::sample_t  mixed;

	assign ready = !valid_q || !out_stall;

	assign rnd   = (stage.prod + alr_pkg::PROD_ROUND) >>> alr_pkg::GAIN_FRAC;
	assign sum   = alr_pkg::wide_t'(rnd) + alr_pkg::wide_t'(stage.x);
	assign mixed = stage.mix ? alr_pkg::sat_sample(sum) : stage.x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= stage_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && stage_valid) begin
			sample_q <= mixed;
			mode_q   <= stage.mode;
			pos_q    <= stage.pos;
			len_q    <= stage.len;
		end
	end

	assign out_valid     = valid_q;
	assign sample_out    = sample_q;
	assign loop_mode     = mode_q;
	assign loop_position = alr_pkg::field_t'(pos_q);
	assign loop_length   = alr_pkg::field_t'(len_q);

endmodule

FILE: hw/rtl/audio_loop_recorder_overdub.sv
// One-channel audio looper: record, play and overdub over a single loop memory.
//
// Input channel (in_valid / in_stall): each item is either a sample (operation 0,
// sample_in in Q1.23) or a command (operation 1: off, record, play, overdub, clear).
// Output channel (out_valid / out_stall): one result item per input item, in order,
// carrying the mixed sample (0 for commands) and mode, position and length after it.
// Throughput is one item per cycle while the output is not stalled. An item passes
// the memory read, the gain multiply and the round/saturate into the output
// register before its result can be taken. Mode, position and length update on the
// accepting edge, so the next item is decoded at once; an overdub write-back to the
// entry that the next item reads in the same cycle is forwarded.
// A stall on the output holds the output register; the stages behind it keep
// filling, and in_stall rises only once the read stage is occupied and cannot move.
// Reset clears mode to off and position and length to zero, and empties the
// pipeline. The loop memory is not cleared: an entry is read only after it was
// recorded.
module audio_loop_recorder_overdub (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   operation,
	input  logic signed [alr_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic [2:0]                             command,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [alr_pkg::SAMPLE_BITS-1:0] sample_out,
	output logic [1:0]                             loop_mode,
	output logic [alr_pkg::FIELD_W-1:0]            loop_position,
	output logic [alr_pkg::FIELD_W-1:0]            loop_length
);

	alr_pkg::req_t      req;
	alr_pkg::mix_req_t  stage;
	logic               stage_valid;
	logic               s1_ready;
	logic               mix_ready;
	logic               accept;

	assign accept   = in_valid && s1_ready;
	assign in_stall = !s1_ready;

	alr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.sample_in (sample_in),
		.command   (command),
		.req       (req)
	);

	alr_store u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req         (req),
		.out_ready   (mix_ready),
		.s1_ready    (s1_ready),
		.stage_valid (stage_valid),
		.stage       (stage)
	);

	alr_mix u_mix (
		.clk           (clk),
		.arst_n        (arst_n),
		.stage_valid   (stage_valid),
		.stage         (stage),
		.out_stall     (out_stall),
		.ready         (mix_ready),
		.out_valid     (out_valid),
		.sample_out    (sample_out),
		.loop_mode     (loop_mode),
		.loop_position (loop_position),
		.loop_length   (loop_length)
	);

endmodule
